[src/cpsd_pkg.sv]
`timescale 1ns / 1ps

package cpsd_pkg;

    // matrix geometry
    localparam int NUM_ROWS   = 5;
    localparam int NUM_COLS   = 5;
    localparam int NUM_LINES  = 6;
    localparam int NUM_GROUPS = 6;

    // apb data width
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    typedef logic [NUM_COLS-1:0]  t_row;
    typedef logic [2:0]           t_group;
    typedef logic [NUM_LINES-1:0] t_lines;

    // last group before wrapping back to zero
    localparam t_group GROUP_LAST = t_group'(NUM_GROUPS - 1);

    // item commands
    typedef enum logic {
        CMD_SHIFT = 1'b0,
        CMD_SCAN  = 1'b1
    } t_cmd;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_BLANK_ON_PRESS = 1'b0,
        REG_NONE           = 1'b1
    } t_reg_idx;

    // configuration seen by the datapath
    typedef struct packed {
        logic blank_on_press;
    } t_cfg;

endpackage

[src/cpsd_in_if.sv]
`timescale 1ns / 1ps

interface cpsd_in_if import cpsd_pkg::*;;
    logic valid;
    logic ready;
    logic command;
    t_row column_bits;
    logic button_low;

    modport source (output valid, output command, output column_bits, output button_low,
                    input ready);
    modport sink   (input valid, input command, input column_bits, input button_low,
                    output ready);
endinterface

[src/cpsd_out_if.sv]
`timescale 1ns / 1ps

interface cpsd_out_if import cpsd_pkg::*;;
    logic   valid;
    logic   ready;
    t_lines line_enable;
    t_lines line_high;
    t_group group_shown;
    logic   press_event;

    modport source (output valid, output line_enable, output line_high, output group_shown,
                    output press_event, input ready);
    modport sink   (input valid, input line_enable, input line_high, input group_shown,
                    input press_event, output ready);
endinterface

[src/cpsd_apb_cfg.sv]
`timescale 1ns / 1ps

module cpsd_apb_cfg import cpsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic     r_blank_on_press;
    t_reg_idx reg_idx;
    logic     wr_en;

    // register decode, word aligned
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_on_press <= 1'b0;
        end else if (wr_en && reg_idx == REG_BLANK_ON_PRESS) begin
            r_blank_on_press <= pwdata[0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_BLANK_ON_PRESS: prdata = {{(APB_DW-1){1'b0}}, r_blank_on_press};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.blank_on_press = r_blank_on_press;

endmodule

[src/cpsd_group_decode.sv]
`timescale 1ns / 1ps

module cpsd_group_decode import cpsd_pkg::*; (
    input  t_row   i_rows [NUM_ROWS],
    input  t_group i_group,
    input  logic   i_blank,
    output t_lines o_line_enable,
    output t_lines o_line_high
);

    t_row   lows;
    t_group row;
    t_lines common;

    // collect lit pixels of the group onto their low lines
    always_comb begin
        lows = '0;
        row  = '0;
        for (int x = 0; x < NUM_COLS; x++) begin
            if (!(i_group != '0 && t_group'(x) == i_group - t_group'(1))) begin
                row = (t_group'(x) < i_group) ? i_group - t_group'(1) : i_group;
                if (i_rows[row][NUM_COLS-1-x]) begin
                    lows[NUM_COLS-1-x] = 1'b1;
                end
            end
        end
    end

    // common line of group g is line 5-g
    assign common = t_lines'(1 << (NUM_LINES - 1)) >> i_group;

    // drive only when something is lit and not blanked
    always_comb begin
        if (!i_blank && lows != '0) begin
            o_line_enable = {1'b0, lows} | common;
            o_line_high   = common;
        end else begin
            o_line_enable = '0;
            o_line_high   = '0;
        end
    end

endmodule

[src/charlieplex_scroll_display_driver.sv]
`timescale 1ns / 1ps
// channel   direction  handshake      payload
// i_item    in         valid/ready    command, column_bits, button_low
// o_result  out        valid/ready    line_enable, line_high, group_shown, press_event
// apb       in         psel/penable   blank_on_press at byte address 0
//
// one item per cycle while the output is taken; each accepted beat gives its result in the
// next cycle from the output register, which is the only stage between the two sides.
// i_item.ready is high while the output register is empty or being taken.
// synchronous active-low reset clears the buffer, group, button history,
// config and output valid.

module charlieplex_scroll_display_driver import cpsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpsd_in_if.sink           i_item,
    cpsd_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg   cfg;
    t_row   r_rows [NUM_ROWS];
    t_group r_group;
    logic   r_was_pressed;
    logic   r_out_valid;
    t_lines r_line_enable;
    t_lines r_line_high;
    t_group r_group_shown;
    logic   r_press_event;

    logic   accept;
    logic   is_scan;
    t_group g;
    logic   blank;
    logic   n_press_event;
    t_lines dec_enable;
    t_lines dec_high;

    cpsd_apb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;
    assign is_scan      = (t_cmd'(i_item.command) == CMD_SCAN);

    // group to show, out-of-range reads as zero
    assign g = (r_group > GROUP_LAST) ? '0 : r_group;

    // button sampling
    assign blank         = cfg.blank_on_press && i_item.button_low;
    assign n_press_event = is_scan && cfg.blank_on_press && i_item.button_low && !r_was_pressed;

    cpsd_group_decode u_decode (
        .i_rows        (r_rows),
        .i_group       (g),
        .i_blank       (blank),
        .o_line_enable (dec_enable),
        .o_line_high   (dec_high)
    );

    // display state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_rows[r] <= '0;
            end
            r_group       <= '0;
            r_was_pressed <= 1'b0;
        end else if (accept) begin
            if (is_scan) begin
                r_group <= (g == GROUP_LAST) ? '0 : g + t_group'(1);
                if (cfg.blank_on_press) begin
                    r_was_pressed <= i_item.button_low;
                end
            end else begin
                for (int r = 0; r < NUM_ROWS; r++) begin
                    r_rows[r] <= {r_rows[r][NUM_COLS-2:0], i_item.column_bits[r]};
                end
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_enable <= is_scan ? dec_enable : '0;
            r_line_high   <= is_scan ? dec_high : '0;
            r_group_shown <= g;
            r_press_event <= n_press_event;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.line_enable = r_line_enable;
    assign o_result.line_high   = r_line_high;
    assign o_result.group_shown = r_group_shown;
    assign o_result.press_event = r_press_event;

endmodule

[verif/cpsd_scan_checker.sv]
`timescale 1ns / 1ps

module cpsd_scan_checker import cpsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpsd_in_if                i_item_mon,
    cpsd_out_if               i_result_mon,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output int                o_pending,
    output int                o_fail_count
);

    typedef struct packed {
        t_lines line_enable;
        t_lines line_high;
        t_group group_shown;
        logic   press_event;
    } t_frame;

    // shadow of the display state
    t_row   pixel_rows [NUM_ROWS];
    t_group scan_pos;
    logic   btn_history;
    logic   blank_mode;

    t_frame expected_frames [$];
    t_frame got_frame;
    t_frame want_frame;
    int     mismatches = 0;

    // next frame for one item, advancing the shadow state
    function automatic t_frame predict_frame(t_cmd cmd, t_row cols, logic btn);
        t_frame f;
        t_group g;
        t_lines lows;
        logic   blank;
        int     r;
        int     x;
        int     row;
        f = '0;
        lows = '0;
        blank = 1'b0;
        g = (scan_pos > GROUP_LAST) ? t_group'(0) : scan_pos;
        f.group_shown = g;
        if (cmd == CMD_SHIFT) begin
            // new column enters on the right of every row
            for (r = 0; r < NUM_ROWS; r++) begin
                pixel_rows[r] = {pixel_rows[r][NUM_COLS-2:0], cols[r]};
            end
            return f;
        end
        if (blank_mode) begin
            f.press_event = btn && !btn_history;
            btn_history = btn;
            blank = btn;
        end
        if (!blank) begin
            // column g-1 is skipped, columns left of it use row g-1
            for (x = 0; x < NUM_COLS; x++) begin
                if (!(g > 0 && x == int'(g) - 1)) begin
                    row = (x < int'(g)) ? int'(g) - 1 : int'(g);
                    if (row < NUM_ROWS && pixel_rows[row][NUM_COLS-1-x]) begin
                        lows[NUM_COLS-1-x] = 1'b1;
                    end
                end
            end
        end
        if (lows != '0) begin
            f.line_high = t_lines'(1) << (NUM_LINES - 1 - int'(g));
            f.line_enable = lows | f.line_high;
        end
        scan_pos = (g >= GROUP_LAST) ? t_group'(0) : t_group'(g + 1);
        return f;
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // compare results, track config, queue predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                pixel_rows[r] = '0;
            end
            scan_pos = '0;
            btn_history = 1'b0;
            blank_mode = 1'b0;
            expected_frames.delete();
        end else begin
            if (i_result_mon.valid && i_result_mon.ready) begin
                got_frame = {i_result_mon.line_enable, i_result_mon.line_high,
                             i_result_mon.group_shown, i_result_mon.press_event};
                if (expected_frames.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, got_frame);
                end else begin
                    want_frame = expected_frames.pop_front();
                    check_field("line_enable", want_frame.line_enable, got_frame.line_enable);
                    check_field("line_high", want_frame.line_high, got_frame.line_high);
                    check_field("group_shown", want_frame.group_shown, got_frame.group_shown);
                    check_field("press_event", want_frame.press_event, got_frame.press_event);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                t_reg_idx'(i_paddr[2]) == REG_BLANK_ON_PRESS) begin
                blank_mode = i_pwdata[0];
            end
            if (i_item_mon.valid && i_item_mon.ready) begin
                expected_frames.push_back(predict_frame(t_cmd'(i_item_mon.command),
                                                        i_item_mon.column_bits,
                                                        i_item_mon.button_low));
            end
        end
        o_pending <= expected_frames.size();
        o_fail_count <= mismatches;
    end

endmodule

[verif/charlieplex_scroll_display_driver_test.sv]
`timescale 1ns / 1ps

module charlieplex_scroll_display_driver_test;
    import cpsd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 80;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int   pending_frames;
    int   fail_count;
    int   send_gap_pct = 0;
    int   take_gap_pct = 0;
    logic hold_off_req = 1'b0;

    cpsd_in_if  item_if ();
    cpsd_out_if result_if ();

    charlieplex_scroll_display_driver u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cpsd_scan_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item_mon   (item_if),
        .i_result_mon (result_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending_frames),
        .o_fail_count (fail_count)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one item beat, with a random gap in front
    task automatic send_beat(t_cmd cmd, t_row cols, logic btn);
        if ($urandom_range(99) < send_gap_pct) begin
            item_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        item_if.valid <= 1'b1;
        item_if.command <= cmd;
        item_if.column_bits <= cols;
        item_if.button_low <= btn;
        do @(posedge clk); while (!(item_if.valid && item_if.ready));
    endtask

    task automatic write_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // stop sending and wait for every frame to come back
    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_frames != 0) @(posedge clk);
    endtask

    // picture updates followed by scan runs, with some stray beats
    task automatic run_random(int beats, int gap_pct, int hold_pct, logic with_hold_off);
        int   sent;
        int   n_shift;
        int   n_scan;
        logic btn;
        logic held;
        t_row cols;
        sent = 0;
        btn = 1'b0;
        held = 1'b0;
        send_gap_pct = gap_pct;
        take_gap_pct = hold_pct;
        while (sent < beats) begin
            if ($urandom_range(9) == 0) begin
                send_beat(t_cmd'($urandom_range(1)), t_row'($urandom), 1'($urandom_range(1)));
                sent++;
            end else begin
                n_shift = $urandom_range(1, 5);
                n_scan = $urandom_range(1, 12);
                repeat (n_shift) begin
                    if ($urandom_range(9) == 0) begin
                        cols = '0;
                    end else if ($urandom_range(9) == 0) begin
                        cols = '1;
                    end else begin
                        cols = t_row'($urandom);
                    end
                    send_beat(CMD_SHIFT, cols, 1'($urandom_range(1)));
                end
                repeat (n_scan) begin
                    if ($urandom_range(3) == 0) btn = ~btn;
                    send_beat(CMD_SCAN, t_row'($urandom), btn);
                end
                sent += n_shift + n_scan;
            end
            if (with_hold_off && !held && sent >= beats / 3) begin
                hold_off_req = 1'b1;
                held = 1'b1;
            end
        end
    endtask

    // result side ready, with a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                result_if.ready <= 1'b0;
                hold_left--;
            end else begin
                result_if.ready <= ($urandom_range(99) >= take_gap_pct);
            end
        end
    end

    // watchdog on cycles without any beat
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_if.valid <= 1'b0;
        item_if.command <= CMD_SHIFT;
        item_if.column_bits <= '0;
        item_if.button_low <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // button released at reset: empty picture, every group dark, group wraps
        repeat (6) send_beat(CMD_SCAN, '0, 1'b0);
        // full picture, all groups lit, pressed button has no effect
        repeat (5) send_beat(CMD_SHIFT, '1, 1'b0);
        repeat (6) send_beat(CMD_SCAN, '0, 1'b1);
        send_beat(CMD_SHIFT, 5'b10101, 1'b1);
        settle();

        // blanking on: press edge, held press, release, shift while pressed, press again
        write_reg(REG_BLANK_ON_PRESS, 32'd1);
        send_beat(CMD_SCAN, '1, 1'b1);
        send_beat(CMD_SCAN, '0, 1'b1);
        send_beat(CMD_SCAN, '0, 1'b0);
        send_beat(CMD_SHIFT, '0, 1'b1);
        send_beat(CMD_SCAN, '0, 1'b1);
        settle();

        write_reg(REG_BLANK_ON_PRESS, 32'd1);
        run_random(245, 16, 49, 1'b1);
        settle();

        write_reg(REG_BLANK_ON_PRESS, 32'd0);
        run_random(245, 49, 16, 1'b0);
        settle();

        write_reg(REG_BLANK_ON_PRESS, 32'd1);
        run_random(245, 0, 0, 1'b0);
        settle();

        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
